// ===== hw/rtl/shre_pkg.sv =====
// Package with the constants, codes and saturating helpers of the sonar height estimator.
`timescale 1ns / 1ps

package shre_pkg;

	localparam int HW = 21;
	localparam int VW = 23;
	localparam int AW = 44;

	typedef logic signed [HW-1:0] height_t;
	typedef logic signed [VW-1:0] speed_t;
	typedef logic signed [AW-1:0] acc_t;

	typedef enum logic [1:0] {
		CFG_FILTER_ORDER  = 2'd0,
		CFG_GATE_ENABLE   = 2'd1,
		CFG_MAX_DEVIATION = 2'd2,
		CFG_STARTUP_ITEMS = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		FO_NONE   = 2'd0,
		FO_FIRST  = 2'd1,
		FO_SECOND = 2'd2,
		FO_SPARE  = 2'd3
	} filter_order_t;

	typedef enum logic [1:0] {
		ACC_NONE = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_ADD  = 2'd2
	} acc_op_t;

	localparam logic signed [17:0] C1_A = 18'sd47612;
	localparam logic signed [17:0] C1_B = 18'sd8959;
	localparam logic signed [17:0] C2_A = 18'sd102303;
	localparam logic signed [17:0] C2_B = -18'sd42032;
	localparam logic signed [17:0] C2_C = 18'sd1316;
	localparam logic signed [17:0] C2_D = 18'sd2633;
	localparam logic signed [17:0] SPEED_GAIN = 18'sd200;

	localparam acc_t H_MAX_A = 44'sd1048575;
	localparam acc_t H_MIN_A = -44'sd1048576;
	localparam acc_t V_MAX_A = 44'sd4194303;
	localparam acc_t V_MIN_A = -44'sd4194304;

	// Coefficient of each filter tap, in the order the taps are issued.
	function automatic logic signed [17:0] filt_coef(input logic second, input logic [2:0] tap);
		logic signed [17:0] c;
		c = C1_B;
		if (second) begin
			unique case (tap)
				3'd0: c = C2_A;
				3'd1: c = C2_B;
				3'd2: c = C2_C;
				3'd3: c = C2_D;
				default: c = C2_C;
			endcase
		end else begin
			c = (tap == 3'd0) ? C1_A : C1_B;
		end
		return c;
	endfunction

	// Division by 2^16 rounding half towards plus infinity.
	function automatic acc_t round_q16(input acc_t v);
		acc_t w;
		w = v + 44'sd32768;
		return w >>> 16;
	endfunction

	function automatic height_t sat_h(input acc_t v);
		height_t r;
		if (v > H_MAX_A)
			r = H_MAX_A[HW-1:0];
		else if (v < H_MIN_A)
			r = H_MIN_A[HW-1:0];
		else
			r = v[HW-1:0];
		return r;
	endfunction

	function automatic speed_t sat_v(input acc_t v);
		speed_t r;
		if (v > V_MAX_A)
			r = V_MAX_A[VW-1:0];
		else if (v < V_MIN_A)
			r = V_MIN_A[VW-1:0];
		else
			r = v[VW-1:0];
		return r;
	endfunction

endpackage

// ===== hw/rtl/sonar_height_rate_estimator_unit.sv =====
// Top level of the sonar height and vertical speed estimator with its shared multiplier.
`timescale 1ns / 1ps

// Takes one sonar transaction at a time and returns one result transaction for it. All
// products (the tilt correction, the filter taps, the speed gain and the speed filter taps)
// pass one after another through a single 37 x 18 bit signed multiplier followed by an
// accumulator. Once accepted, an item steps through the gate, the tilt correction (for a
// reading that passes it), the height filter taps, the speed gain and the speed filter taps.
// in_stall stays high until the result has been moved into the output register; a held
// result does not stop the next transaction from being accepted.
module sonar_height_rate_estimator_unit
	import shre_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [16:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [9:0]        sonar_cm,
	input  logic [15:0]       cos_roll,
	input  logic [15:0]       cos_pitch,
	input  logic              auto_height,
	output logic              out_valid,
	input  logic              out_stall,
	output logic signed [20:0] height,
	output logic signed [22:0] vertical_speed,
	output logic              in_startup
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_GATE, ST_TILT1, ST_TILT2, ST_TILT3, ST_FTAP, ST_FACC, ST_FRND,
		ST_DZMUL, ST_DZSAT, ST_STAP, ST_SACC, ST_SRND, ST_OUT
	} state_t;

	state_t state_q;

	logic [1:0]  filter_order_q;
	logic        gate_enable_q;
	logic [16:0] max_deviation_q;
	logic [9:0]  startup_items_q;

	logic [9:0]  item_count_q;
	height_t     held_q, ref_q, in1_q, in2_q, out1_q, out2_q, prev_q, filt_q;
	speed_t      spd_in_q, spd_out_q, dz_q;

	logic [19:0] scaled_q;
	logic [15:0] cr_q, cp_q;
	logic        auto_q, startup_q;
	logic [2:0]  tap_q;

	logic signed [54:0] prod_q;
	acc_t               acc_q;
	acc_op_t            acc_op_q;

	logic              out_valid_q, in_startup_q;
	height_t           height_q;
	speed_t            vspeed_q;

	// Combinational signals
	logic [15:0] frac_w;
	logic [28:0] frac_p;
	logic [19:0] scaled_c;
	logic        accept, startup_c, correct_c, second, tap_last;
	logic signed [22:0] win_lo, win_hi, scaled_s;
	logic signed [36:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [54:0] mul_p;
	acc_op_t     acc_op_c;
	logic [53:0] tilt_sum;
	logic [23:0] tilt_r;
	height_t     filt_c;
	speed_t      spd_c;
	state_t      filt_next;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign startup_c = item_count_q < startup_items_q;

	// cm * 65536 / 100 split as cm * 655 + (cm * 36 + 50) / 100; the small quotient uses a
	// reciprocal that is exact below 43690.
	assign frac_w   = 16'(sonar_cm * 6'd36) + 16'd50;
	assign frac_p   = 29'(frac_w * 13'd5243);
	assign scaled_c = 20'(sonar_cm * 10'd655) + 20'(frac_p[28:19]);

	assign scaled_s  = 23'(scaled_q);
	assign win_lo    = 23'(ref_q) - 23'(max_deviation_q);
	assign win_hi    = 23'(ref_q) + 23'(max_deviation_q);
	assign correct_c = !gate_enable_q || startup_q || ((win_lo < scaled_s) && (win_hi > scaled_s));

	assign second   = (filter_order_q == FO_SECOND);
	assign tap_last = second ? (tap_q == 3'd4) : (tap_q == 3'd2);
	assign filt_next = (filter_order_q == FO_FIRST || filter_order_q == FO_SECOND) ?
		ST_FTAP : ST_FRND;

	assign tilt_sum = {1'b0, prod_q[52:0]} + 54'h0000_2000_0000;
	assign tilt_r   = tilt_sum[53:30];

	assign filt_c = sat_h(round_q16(acc_q));
	assign spd_c  = sat_v(round_q16(acc_q));

	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		acc_op_c = ACC_NONE;
		unique case (state_q)
			ST_TILT1: begin
				mul_a = 37'(scaled_q);
				mul_b = 18'(cr_q);
			end
			ST_TILT2: begin
				mul_a = 37'(prod_q[35:0]);
				mul_b = 18'(cp_q);
			end
			ST_FTAP: begin
				mul_b    = filt_coef(second, tap_q);
				acc_op_c = (tap_q == 3'd0) ? ACC_LOAD : ACC_ADD;
				if (second) begin
					unique case (tap_q)
						3'd0: mul_a = 37'(out1_q);
						3'd1: mul_a = 37'(out2_q);
						3'd2: mul_a = 37'(held_q);
						3'd3: mul_a = 37'(in1_q);
						default: mul_a = 37'(in2_q);
					endcase
				end else begin
					unique case (tap_q)
						3'd0: mul_a = 37'(out1_q);
						3'd1: mul_a = 37'(held_q);
						default: mul_a = 37'(in1_q);
					endcase
				end
			end
			ST_DZMUL: begin
				mul_a = 37'(22'(filt_q) - 22'(prev_q));
				mul_b = SPEED_GAIN;
			end
			ST_STAP: begin
				acc_op_c = (tap_q == 3'd0) ? ACC_LOAD : ACC_ADD;
				unique case (tap_q)
					3'd0: begin
						mul_a = 37'(spd_out_q);
						mul_b = C1_A;
					end
					3'd1: begin
						mul_a = 37'(dz_q);
						mul_b = C1_B;
					end
					default: begin
						mul_a = 37'(spd_in_q);
						mul_b = C1_B;
					end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			filter_order_q  <= FO_FIRST;
			gate_enable_q   <= 1'b1;
			max_deviation_q <= 17'd19661;
			startup_items_q <= 10'd100;
			item_count_q    <= '0;
			held_q          <= '0;
			ref_q           <= '0;
			in1_q           <= '0;
			in2_q           <= '0;
			out1_q          <= '0;
			out2_q          <= '0;
			prev_q          <= '0;
			filt_q          <= '0;
			spd_in_q        <= '0;
			spd_out_q       <= '0;
			dz_q            <= '0;
			scaled_q        <= '0;
			cr_q            <= '0;
			cp_q            <= '0;
			auto_q          <= 1'b0;
			startup_q       <= 1'b0;
			tap_q           <= '0;
			prod_q          <= '0;
			acc_q           <= '0;
			acc_op_q        <= ACC_NONE;
			out_valid_q     <= 1'b0;
			in_startup_q    <= 1'b0;
			height_q        <= '0;
			vspeed_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index_t'(cfg_index))
					CFG_FILTER_ORDER:  filter_order_q  <= cfg_data[1:0];
					CFG_GATE_ENABLE:   gate_enable_q   <= cfg_data[0];
					CFG_MAX_DEVIATION: max_deviation_q <= cfg_data;
					CFG_STARTUP_ITEMS: startup_items_q <= cfg_data[9:0];
					default: ;
				endcase
			end

			prod_q   <= mul_p;
			acc_op_q <= acc_op_c;
			unique case (acc_op_q)
				ACC_LOAD: acc_q <= $signed(prod_q[AW-1:0]);
				ACC_ADD:  acc_q <= acc_q + $signed(prod_q[AW-1:0]);
				default:  acc_q <= acc_q;
			endcase

			if (state_q == ST_OUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scaled_q  <= scaled_c;
						cr_q      <= cos_roll;
						cp_q      <= cos_pitch;
						auto_q    <= auto_height;
						startup_q <= startup_c;
						if (startup_c)
							item_count_q <= item_count_q + 10'd1;
						state_q <= ST_GATE;
					end
				end
				ST_GATE: begin
					tap_q   <= '0;
					state_q <= correct_c ? ST_TILT1 : filt_next;
				end
				ST_TILT1: state_q <= ST_TILT2;
				ST_TILT2: state_q <= ST_TILT3;
				ST_TILT3: begin
					held_q  <= (tilt_r > 24'd1048575) ? H_MAX_A[HW-1:0] : tilt_r[HW-1:0];
					state_q <= filt_next;
				end
				ST_FTAP: begin
					tap_q <= tap_q + 3'd1;
					if (tap_last)
						state_q <= ST_FACC;
				end
				ST_FACC: state_q <= ST_FRND;
				ST_FRND: begin
					if (filter_order_q == FO_FIRST) begin
						filt_q <= filt_c;
						in1_q  <= held_q;
						out1_q <= filt_c;
					end else if (filter_order_q == FO_SECOND) begin
						filt_q <= filt_c;
						in2_q  <= in1_q;
						in1_q  <= held_q;
						out2_q <= out1_q;
						out1_q <= filt_c;
					end else begin
						filt_q <= held_q;
					end
					state_q <= ST_DZMUL;
				end
				ST_DZMUL: state_q <= ST_DZSAT;
				ST_DZSAT: begin
					dz_q    <= sat_v($signed(prod_q[AW-1:0]));
					tap_q   <= '0;
					state_q <= ST_STAP;
				end
				ST_STAP: begin
					tap_q <= tap_q + 3'd1;
					if (tap_q == 3'd2)
						state_q <= ST_SACC;
				end
				ST_SACC: state_q <= ST_SRND;
				ST_SRND: begin
					spd_out_q <= spd_c;
					spd_in_q  <= dz_q;
					prev_q    <= filt_q;
					if (!auto_q)
						ref_q <= filt_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						height_q     <= filt_q;
						vspeed_q     <= spd_out_q;
						in_startup_q <= startup_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign height         = height_q;
	assign vertical_speed = vspeed_q;
	assign in_startup     = in_startup_q;

`ifndef NO_ASSERTIONS
	// A transaction that has been taken keeps the input side closed until its result is out.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input not stalled after a transaction was accepted");

	// Accumulation always continues a chain that began with a load.
	a_acc_chain: assert property (@(posedge clk) disable iff (!arst_n)
		acc_op_q == ACC_ADD |-> $past(acc_op_q) == ACC_LOAD || $past(acc_op_q) == ACC_ADD)
		else $error("accumulator add without a preceding load");

	// A new result only appears from the output step of the sequencer.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result raised outside the output step");

	// The tilt-corrected height is saturated to the positive range.
	a_held_positive: assert property (@(posedge clk) disable iff (!arst_n)
		!held_q[HW-1])
		else $error("corrected height went negative");
`endif

endmodule
